// ----- src/vcsg_pkg.sv -----
`timescale 1ns / 1ps

package vcsg_pkg;

  localparam int unsigned MaxWorkers = 16;
  localparam int unsigned WorkerW    = 4;
  localparam int unsigned CountW     = 32;
  localparam int unsigned HoldDepth  = 16;
  localparam int unsigned HoldPtrW   = 4;
  localparam int unsigned HoldCntW   = 5;
  localparam int unsigned PendW      = 5;
  localparam int unsigned ResLimit   = 32;
  localparam int unsigned ResPtrW    = 5;
  localparam int unsigned ResCntW    = 6;
  localparam int unsigned CfgW       = 5;

  localparam logic [CfgW-1:0] CfgReset = 5'd16;
  localparam logic            KindAdd  = 1'b0;
  localparam logic            KindGet  = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_GET = 2'd1,
    OP_FIN = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INC,
    S_SCAN,
    S_SCLR,
    S_EVAL,
    S_DISP,
    S_DGPOP,
    S_DGCHK,
    S_DAPOP,
    S_DAPEND,
    S_FLUSH,
    S_OUT
  } state_e;

  // What the current clock update belongs to, and where control goes after it.
  typedef enum logic [2:0] {
    CX_ADD,
    CX_GET,
    CX_FINA,
    CX_FING,
    CX_DGN,
    CX_DGS,
    CX_DA
  } ctx_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [WorkerW-1:0] worker_id;
  } req_t;

  typedef struct packed {
    logic               grant_kind;
    logic [WorkerW-1:0] grant_worker;
    logic               error;
    logic               last;
  } res_t;

  typedef struct packed {
    logic latch;
    logic sel_get;
    logic scan_addr;
    logic scan_clr;
    logic scan_en;
    logic inc;
    logic eval;
    logic fin_mode;
    logic skip;
    logic hold_add;
    logic hold_get;
    logic mark_fin;
    logic emit;
    logic emit_kind;
    logic pop_get;
    logic pop_add;
    logic pend_dec;
    logic set_err;
    logic out_en;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic invalid;
    logic add_ahead;
    logic get_ahead;
    logic pend_nz;
    logic caught;
    logic scan_last;
    logic add_cnt_nz;
    logic get_cnt_nz;
    logic tgt_gone;
    logic res_empty;
    logic err;
    logic out_last;
  } sts_t;

endpackage

// ----- src/vcsg_ctrl.sv -----
`timescale 1ns / 1ps

module vcsg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  vcsg_pkg::sts_t sts_i,
  output vcsg_pkg::cmd_t cmd_o,
  output logic           busy_o
);

  vcsg_pkg::state_e state_q, state_d;
  vcsg_pkg::ctx_e   ctx_q, ctx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vcsg_pkg::S_IDLE;
      ctx_q   <= vcsg_pkg::CX_ADD;
    end else begin
      state_q <= state_d;
      ctx_q   <= ctx_d;
    end
  end

  assign busy_o = (state_q != vcsg_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    ctx_d   = ctx_q;
    cmd_o   = '0;
    cmd_o.sel_get   = (ctx_q == vcsg_pkg::CX_GET) || (ctx_q == vcsg_pkg::CX_FING) ||
                      (ctx_q == vcsg_pkg::CX_DGN) || (ctx_q == vcsg_pkg::CX_DGS);
    cmd_o.skip      = (ctx_q == vcsg_pkg::CX_DGS);
    cmd_o.scan_addr = (state_q == vcsg_pkg::S_SCAN);
    cmd_o.fin_mode  = (ctx_q == vcsg_pkg::CX_FINA) || (ctx_q == vcsg_pkg::CX_FING);
    case (state_q)
      vcsg_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d = vcsg_pkg::S_CHECK;
        end
      end
      vcsg_pkg::S_CHECK: begin
        if (sts_i.op == vcsg_pkg::OP_NOP) begin
          state_d = vcsg_pkg::S_IDLE;
        end else if (sts_i.invalid) begin
          if (sts_i.op == vcsg_pkg::OP_FIN) begin
            state_d = vcsg_pkg::S_IDLE;
          end else begin
            cmd_o.set_err = 1'b1;
            state_d = vcsg_pkg::S_FLUSH;
          end
        end else begin
          case (sts_i.op)
            vcsg_pkg::OP_ADD: begin
              if (sts_i.get_ahead) begin
                cmd_o.hold_add = 1'b1;
                state_d = vcsg_pkg::S_FLUSH;
              end else begin
                cmd_o.emit = 1'b1;
                cmd_o.emit_kind = vcsg_pkg::KindAdd;
                ctx_d = vcsg_pkg::CX_ADD;
                state_d = vcsg_pkg::S_INC;
              end
            end
            vcsg_pkg::OP_GET: begin
              if (sts_i.add_ahead || sts_i.pend_nz) begin
                cmd_o.hold_get = 1'b1;
                state_d = vcsg_pkg::S_FLUSH;
              end else begin
                cmd_o.emit = 1'b1;
                cmd_o.emit_kind = vcsg_pkg::KindGet;
                ctx_d = vcsg_pkg::CX_GET;
                state_d = vcsg_pkg::S_INC;
              end
            end
            default: begin
              cmd_o.mark_fin = 1'b1;
              ctx_d = vcsg_pkg::CX_FINA;
              state_d = vcsg_pkg::S_SCLR;
            end
          endcase
        end
      end
      vcsg_pkg::S_INC: begin
        cmd_o.inc = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d = vcsg_pkg::S_SCAN;
      end
      vcsg_pkg::S_SCLR: begin
        cmd_o.scan_clr = 1'b1;
        state_d = vcsg_pkg::S_SCAN;
      end
      vcsg_pkg::S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = vcsg_pkg::S_EVAL;
        end
      end
      vcsg_pkg::S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = vcsg_pkg::S_DISP;
      end
      vcsg_pkg::S_DISP: begin
        case (ctx_q)
          vcsg_pkg::CX_ADD: begin
            if (sts_i.caught) begin
              cmd_o.set_err = sts_i.add_cnt_nz;
              ctx_d = vcsg_pkg::CX_DGN;
              state_d = vcsg_pkg::S_DGPOP;
            end else begin
              state_d = vcsg_pkg::S_FLUSH;
            end
          end
          vcsg_pkg::CX_GET: begin
            if (sts_i.caught) begin
              ctx_d = vcsg_pkg::CX_DA;
              state_d = vcsg_pkg::S_DAPOP;
            end else begin
              state_d = vcsg_pkg::S_FLUSH;
            end
          end
          vcsg_pkg::CX_FINA: begin
            if (sts_i.caught) begin
              cmd_o.set_err = sts_i.add_cnt_nz;
              ctx_d = vcsg_pkg::CX_DGS;
              state_d = vcsg_pkg::S_DGPOP;
            end else begin
              ctx_d = vcsg_pkg::CX_FING;
              state_d = vcsg_pkg::S_SCLR;
            end
          end
          vcsg_pkg::CX_FING: begin
            if (sts_i.caught) begin
              cmd_o.set_err = sts_i.get_cnt_nz;
              ctx_d = vcsg_pkg::CX_DA;
              state_d = vcsg_pkg::S_DAPOP;
            end else begin
              state_d = vcsg_pkg::S_FLUSH;
            end
          end
          vcsg_pkg::CX_DA: begin
            cmd_o.set_err = sts_i.caught;
            state_d = vcsg_pkg::S_DAPOP;
          end
          default: begin
            cmd_o.set_err = sts_i.caught;
            state_d = vcsg_pkg::S_DGPOP;
          end
        endcase
      end
      vcsg_pkg::S_DGPOP: begin
        if (sts_i.get_cnt_nz) begin
          cmd_o.pop_get = 1'b1;
          cmd_o.emit_kind = vcsg_pkg::KindGet;
          state_d = vcsg_pkg::S_DGCHK;
        end else if (ctx_q == vcsg_pkg::CX_DGS) begin
          ctx_d = vcsg_pkg::CX_FING;
          state_d = vcsg_pkg::S_SCLR;
        end else begin
          state_d = vcsg_pkg::S_FLUSH;
        end
      end
      vcsg_pkg::S_DGCHK: begin
        state_d = sts_i.tgt_gone ? vcsg_pkg::S_DGPOP : vcsg_pkg::S_INC;
      end
      vcsg_pkg::S_DAPOP: begin
        if (sts_i.add_cnt_nz) begin
          cmd_o.pop_add = 1'b1;
          cmd_o.emit_kind = vcsg_pkg::KindAdd;
          state_d = vcsg_pkg::S_DAPEND;
        end else begin
          state_d = vcsg_pkg::S_FLUSH;
        end
      end
      vcsg_pkg::S_DAPEND: begin
        cmd_o.pend_dec = 1'b1;
        state_d = sts_i.tgt_gone ? vcsg_pkg::S_DAPOP : vcsg_pkg::S_INC;
      end
      vcsg_pkg::S_FLUSH: begin
        if (sts_i.res_empty) begin
          if (sts_i.err) begin
            cmd_o.emit = 1'b1;
            cmd_o.emit_kind = (sts_i.op == vcsg_pkg::OP_GET);
            state_d = vcsg_pkg::S_OUT;
          end else begin
            state_d = vcsg_pkg::S_IDLE;
          end
        end else begin
          state_d = vcsg_pkg::S_OUT;
        end
      end
      vcsg_pkg::S_OUT: begin
        cmd_o.out_en = 1'b1;
        if (sts_i.out_last) begin
          state_d = vcsg_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = vcsg_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/vcsg_dp.sv -----
`timescale 1ns / 1ps

module vcsg_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  vcsg_pkg::req_t            req_i,
  input  logic                      cfg_we_i,
  input  logic [vcsg_pkg::CfgW-1:0] cfg_data_i,
  input  vcsg_pkg::cmd_t            cmd_i,
  output vcsg_pkg::sts_t            sts_o,
  output logic                      res_valid_o,
  output vcsg_pkg::res_t            res_o
);

  localparam int unsigned CW = vcsg_pkg::CountW;
  localparam int unsigned WW = vcsg_pkg::WorkerW;

  logic [vcsg_pkg::CfgW-1:0] cfg_q;
  logic [1:0]                op_q;
  logic [WW-1:0]             w_q, tgt_q, idx_q;
  logic                      err_q, caught_q, any_q;
  logic [CW-1:0]             add_loc_q [vcsg_pkg::MaxWorkers];
  logic [CW-1:0]             get_loc_q [vcsg_pkg::MaxWorkers];
  logic [vcsg_pkg::PendW-1:0] pend_q   [vcsg_pkg::MaxWorkers];
  logic [vcsg_pkg::MaxWorkers-1:0] fin_q;
  logic [CW-1:0]             add_glob_q, get_glob_q, max_q;
  logic [CW:0]               min_q;
  logic [WW-1:0]             afifo_q [vcsg_pkg::HoldDepth];
  logic [WW-1:0]             gfifo_q [vcsg_pkg::HoldDepth];
  logic [vcsg_pkg::HoldPtrW-1:0] ahead_q, ghead_q;
  logic [vcsg_pkg::HoldCntW-1:0] acnt_q, gcnt_q;
  logic                      rkind_q [vcsg_pkg::ResLimit];
  logic [WW-1:0]             rwork_q [vcsg_pkg::ResLimit];
  logic [vcsg_pkg::ResCntW-1:0] res_n_q;
  logic [vcsg_pkg::ResPtrW-1:0] ptr_q;
  logic                      res_valid_q;
  vcsg_pkg::res_t            res_q;

  logic [vcsg_pkg::CfgW-1:0] n_act;
  logic [WW-1:0]             addr, emit_w;
  logic [CW-1:0]             loc_rd, glob_rd;
  logic                      idx_gone, out_last, do_emit, full_a, full_g;

  always_comb begin
    if (cfg_q == '0) begin
      n_act = vcsg_pkg::CfgW'(1);
    end else if (cfg_q > vcsg_pkg::CfgW'(vcsg_pkg::MaxWorkers)) begin
      n_act = vcsg_pkg::CfgW'(vcsg_pkg::MaxWorkers);
    end else begin
      n_act = cfg_q;
    end
  end

  assign addr     = cmd_i.scan_addr ? idx_q : tgt_q;
  assign loc_rd   = cmd_i.sel_get ? get_loc_q[addr] : add_loc_q[addr];
  assign glob_rd  = cmd_i.sel_get ? get_glob_q : add_glob_q;
  assign idx_gone = fin_q[idx_q] && !(cmd_i.skip && idx_q == w_q);
  assign out_last = ({1'b0, ptr_q} == res_n_q - vcsg_pkg::ResCntW'(1));
  assign do_emit  = cmd_i.emit || cmd_i.pop_get || cmd_i.pop_add;
  assign emit_w   = cmd_i.pop_get ? gfifo_q[ghead_q] :
                    cmd_i.pop_add ? afifo_q[ahead_q] : w_q;
  assign full_a   = (acnt_q == vcsg_pkg::HoldCntW'(vcsg_pkg::HoldDepth));
  assign full_g   = (gcnt_q == vcsg_pkg::HoldCntW'(vcsg_pkg::HoldDepth));

  always_comb begin
    sts_o.op         = vcsg_pkg::op_e'(op_q);
    sts_o.invalid    = ({1'b0, w_q} >= n_act) || fin_q[w_q];
    sts_o.add_ahead  = add_loc_q[tgt_q] > add_glob_q;
    sts_o.get_ahead  = get_loc_q[tgt_q] > get_glob_q;
    sts_o.pend_nz    = (pend_q[tgt_q] != '0);
    sts_o.caught     = caught_q;
    sts_o.scan_last  = ({1'b0, idx_q} == n_act - vcsg_pkg::CfgW'(1));
    sts_o.add_cnt_nz = (acnt_q != '0);
    sts_o.get_cnt_nz = (gcnt_q != '0);
    sts_o.tgt_gone   = fin_q[tgt_q] && !(cmd_i.skip && tgt_q == w_q);
    sts_o.res_empty  = (res_n_q == '0);
    sts_o.err        = err_q;
    sts_o.out_last   = out_last;
  end

  // Control state and the clocks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= vcsg_pkg::CfgReset;
      err_q       <= 1'b0;
      caught_q    <= 1'b0;
      fin_q       <= '0;
      add_glob_q  <= '0;
      get_glob_q  <= '0;
      ahead_q     <= '0;
      ghead_q     <= '0;
      acnt_q      <= '0;
      gcnt_q      <= '0;
      res_n_q     <= '0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < vcsg_pkg::MaxWorkers; i++) begin
        add_loc_q[i] <= '0;
        get_loc_q[i] <= '0;
        pend_q[i]    <= '0;
      end
    end else begin
      res_valid_q <= cmd_i.out_en;
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (cmd_i.latch) begin
        err_q   <= 1'b0;
        res_n_q <= '0;
        ptr_q   <= '0;
      end
      if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
      if (cmd_i.mark_fin) begin
        fin_q[w_q] <= 1'b1;
      end
      if (cmd_i.inc) begin
        if (loc_rd == '1) begin
          err_q <= 1'b1;
        end else if (cmd_i.sel_get) begin
          get_loc_q[tgt_q] <= loc_rd + CW'(1);
        end else begin
          add_loc_q[tgt_q] <= loc_rd + CW'(1);
        end
      end
      if (cmd_i.eval) begin
        caught_q <= 1'b0;
        if ({1'b0, glob_rd} < min_q) begin
          if (!cmd_i.fin_mode) begin
            caught_q <= !any_q || (max_q <= glob_rd + CW'(1));
            if (cmd_i.sel_get) get_glob_q <= glob_rd + CW'(1);
            else               add_glob_q <= glob_rd + CW'(1);
          end else if (!any_q) begin
            caught_q <= 1'b1;
          end else begin
            caught_q <= (max_q <= min_q[CW-1:0]);
            if (cmd_i.sel_get) get_glob_q <= min_q[CW-1:0];
            else               add_glob_q <= min_q[CW-1:0];
          end
        end
      end
      if (cmd_i.hold_add) begin
        if (full_a) begin
          err_q <= 1'b1;
        end else begin
          acnt_q     <= acnt_q + vcsg_pkg::HoldCntW'(1);
          pend_q[w_q] <= pend_q[w_q] + vcsg_pkg::PendW'(1);
        end
      end
      if (cmd_i.hold_get) begin
        if (full_g) begin
          err_q <= 1'b1;
        end else begin
          gcnt_q <= gcnt_q + vcsg_pkg::HoldCntW'(1);
        end
      end
      if (cmd_i.pop_get) begin
        ghead_q <= ghead_q + vcsg_pkg::HoldPtrW'(1);
        gcnt_q  <= gcnt_q - vcsg_pkg::HoldCntW'(1);
      end
      if (cmd_i.pop_add) begin
        ahead_q <= ahead_q + vcsg_pkg::HoldPtrW'(1);
        acnt_q  <= acnt_q - vcsg_pkg::HoldCntW'(1);
      end
      if (cmd_i.pend_dec) begin
        if (pend_q[tgt_q] == '0) begin
          err_q <= 1'b1;
        end else begin
          pend_q[tgt_q] <= pend_q[tgt_q] - vcsg_pkg::PendW'(1);
        end
      end
      if (do_emit && res_n_q < vcsg_pkg::ResCntW'(vcsg_pkg::ResLimit)) begin
        res_n_q <= res_n_q + vcsg_pkg::ResCntW'(1);
      end
      if (cmd_i.out_en) begin
        ptr_q <= ptr_q + vcsg_pkg::ResPtrW'(1);
      end
    end
  end

  // Payload registers: request, scan accumulators, queues and result buffer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= req_i.operation;
      w_q   <= req_i.worker_id;
      tgt_q <= req_i.worker_id;
    end
    if (cmd_i.pop_get || cmd_i.pop_add) begin
      tgt_q <= emit_w;
    end
    if (cmd_i.scan_clr) begin
      idx_q <= '0;
      min_q <= {1'b1, {CW{1'b0}}};
      max_q <= '0;
      any_q <= 1'b0;
    end else if (cmd_i.scan_en) begin
      idx_q <= idx_q + WW'(1);
      if (!idx_gone) begin
        any_q <= 1'b1;
        if ({1'b0, loc_rd} < min_q) min_q <= {1'b0, loc_rd};
        if (!any_q || loc_rd > max_q) max_q <= loc_rd;
      end
    end
    if (cmd_i.hold_add && !full_a) begin
      afifo_q[ahead_q + acnt_q[vcsg_pkg::HoldPtrW-1:0]] <= w_q;
    end
    if (cmd_i.hold_get && !full_g) begin
      gfifo_q[ghead_q + gcnt_q[vcsg_pkg::HoldPtrW-1:0]] <= w_q;
    end
    if (do_emit && res_n_q < vcsg_pkg::ResCntW'(vcsg_pkg::ResLimit)) begin
      rkind_q[res_n_q[vcsg_pkg::ResPtrW-1:0]] <= cmd_i.emit_kind;
      rwork_q[res_n_q[vcsg_pkg::ResPtrW-1:0]] <= emit_w;
    end
    if (cmd_i.out_en) begin
      res_q.grant_kind   <= rkind_q[ptr_q];
      res_q.grant_worker <= rwork_q[ptr_q];
      res_q.error        <= err_q;
      res_q.last         <= out_last;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- src/vector_clock_sync_gate_unit.sv -----
`timescale 1ns / 1ps

// Barrier gate for synchronous training with an add clock and a get clock.
// A request is taken when start_i is high and busy_o is low. busy_o then stays
// high until the last result beat of that request has been issued; that last
// beat is shown in the first cycle in which busy_o is low again. Each result
// beat appears on res_o for exactly one cycle with res_valid_o high and cannot
// be held off, so the receiver must take every beat as it comes. All beats of
// one request carry the same error bit and the final one has last set; a
// request may give no beat at all (a held request, a finish without error, an
// ignored operation). Steps: the request is checked first; every add or get
// clock update goes through an increment step (a finish update through a
// clear step instead), a scan over the active workers (as many as the clamped
// active_workers value) and two evaluation steps; each drained request adds
// two steps (a pop and a check) plus its clock update; the beats then follow
// back to back, one per cycle. active_workers is written through the cfg
// channel, which is ready only while the block is idle.
module vector_clock_sync_gate_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  vcsg_pkg::req_t            req_i,
  output logic                      res_valid_o,
  output vcsg_pkg::res_t            res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [vcsg_pkg::CfgW-1:0] cfg_data_i
);

  vcsg_pkg::cmd_t cmd;
  vcsg_pkg::sts_t sts;
  logic           busy;

  vcsg_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  vcsg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i && !busy),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  assign busy_o      = busy;
  assign cfg_ready_o = !busy;

endmodule

// ----- src/vcsg_checker.sv -----
`timescale 1ns / 1ps

module vcsg_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      res_valid_o,
  input vcsg_pkg::res_t            res_o,
  input logic                      cfg_ready_o
);

  // Configuration is only taken while no request is in flight.
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == !busy_o) else $error("cfg ready while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted request did not raise busy");

  // Beats of one request come back to back and share one error bit.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o && res_o.error == $past(res_o.error))
    else $error("result burst broken");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy_o) else $error("idle before last beat");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o) else $error("beat after last");

endmodule

bind vector_clock_sync_gate_unit vcsg_checker u_vcsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o),
  .cfg_ready_o (cfg_ready_o)
);
